FILE: hdl/linear_probe_hash_table_defines.svh
// Assertion helper macros for the hash table block.
`ifndef LINEAR_PROBE_HASH_TABLE_DEFINES_SVH
`define LINEAR_PROBE_HASH_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
`define LPHT_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define LPHT_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define LPHT_ASSERT(label, clk, rst, prop)
`define LPHT_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

FILE: hdl/lpht_pkg.sv
package lpht_pkg;
  localparam int unsigned OP_W = 3;
  localparam int unsigned KEY_W = 32;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned STAT_W = 2;

  localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OP_W-1:0] OP_SEARCH = 3'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd2;
  localparam logic [OP_W-1:0] OP_PAIR   = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

  localparam logic [STAT_W-1:0] RES_OK   = 2'd0;
  localparam logic [STAT_W-1:0] RES_MISS = 2'd1;
  localparam logic [STAT_W-1:0] RES_FULL = 2'd2;

  localparam logic [1:0] SLOT_EMPTY = 2'd0;
  localparam logic [1:0] SLOT_USED  = 2'd1;
  localparam logic [1:0] SLOT_GONE  = 2'd2;

  // Classified command handed from front to back.
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [KEY_W-1:0]  key;    // key to store
    logic [KEY_W-1:0]  look;   // key to look up (partner key for pair step)
    logic [DATA_W-1:0] data;
  } cmd_t;

  typedef struct packed {
    logic              found;
    logic [DATA_W-1:0] data;
    logic [STAT_W-1:0] status;
  } res_t;
endpackage

FILE: hdl/lpht_front.sv
module lpht_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [lpht_pkg::OP_W-1:0]   in_op,
  input  logic [lpht_pkg::KEY_W-1:0]  in_key,
  input  logic [lpht_pkg::DATA_W-1:0] in_data,
  output logic                q_valid,
  input  logic                q_ready,
  output lpht_pkg::cmd_t      q_cmd
);
  import lpht_pkg::*;

  logic [KEY_W-1:0] pair_target;
  cmd_t cmd_q [2];
  logic wp, rp;
  logic [1:0] count;

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_cmd    = cmd_q[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_target <= '0;
    end else if (cfg_we) begin
      pair_target <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_q[wp].op   <= in_op;
      cmd_q[wp].key  <= in_key;
      cmd_q[wp].look <= (in_op == OP_PAIR) ? pair_target - in_key : in_key;
      cmd_q[wp].data <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= '0;
    end else begin
      if (in_valid && in_ready) wp <= ~wp;
      if (q_valid && q_ready) rp <= ~rp;
      count <= count + 2'((in_valid && in_ready) ? 1 : 0) - 2'((q_valid && q_ready) ? 1 : 0);
    end
  end
endmodule

FILE: hdl/lpht_back.sv
`include "linear_probe_hash_table_defines.svh"
module lpht_back #(
  parameter int unsigned TABLE_SLOTS = 256
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  output logic           q_ready,
  input  lpht_pkg::cmd_t q_cmd,
  output logic           res_valid,
  input  logic           res_ready,
  output lpht_pkg::res_t res
);
  import lpht_pkg::*;
  localparam int unsigned IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int unsigned CW = $clog2(TABLE_SLOTS + 1);
  localparam logic [IW-1:0] LAST = IW'(TABLE_SLOTS - 1);
  // Reciprocal for the home slot: q = (u * RECIP) >> (32 + SH) is exact for 32-bit u.
  localparam int unsigned SH = $clog2(TABLE_SLOTS);
  localparam longint unsigned RECIP_L =
      ((64'd1 << (32 + SH)) + 64'(TABLE_SLOTS) - 64'd1) / 64'(TABLE_SLOTS);
  localparam logic [32:0] RECIP = 33'(RECIP_L);
  localparam logic [31:0] SLOTS_W = 32'(TABLE_SLOTS);
  localparam logic [CW-1:0] SLOTS_C = CW'(TABLE_SLOTS);
  localparam logic [CW-1:0] HALF_REM = CW'((64'd1 << 31) % 64'(TABLE_SLOTS));
  localparam logic [KEY_W-1:0] SIGN_BIT = {1'b1, {(KEY_W-1){1'b0}}};

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_HASH  = 7'b0000010,
    S_READ  = 7'b0000100,
    S_CHECK = 7'b0001000,
    S_FILL  = 7'b0010000,
    S_CLEAR = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state;
  cmd_t cmd;
  logic [1:0] stat_mem [TABLE_SLOTS];
  logic [KEY_W-1:0] key_mem [TABLE_SLOTS];
  logic [DATA_W-1:0] data_mem [TABLE_SLOTS];
  logic [1:0] rd_stat;
  logic [KEY_W-1:0] rd_key;
  logic [DATA_W-1:0] rd_data;
  logic [IW-1:0] addr;
  logic [CW-1:0] probes;
  logic hit_any, insert_phase;
  logic out_full;
  logic [31:0] hash_u, hash_q, hash_r;
  logic [CW-1:0] hash_rem;
  logic [IW-1:0] hash_home;
  logic [KEY_W-1:0] idle_src, pair_src;

  // Quotient of the offset key by the slot count.
  function automatic logic [31:0] recip_quot(input logic [31:0] u);
    logic [64:0] p;
    p = 65'(u) * 65'(RECIP);
    return 32'(p >> (32 + SH));
  endfunction

  function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] a);
    return (a == LAST) ? '0 : a + IW'(1);
  endfunction

  // Offset the signed key by 2^31 so it is unsigned, reduce, then remove
  // the offset's remainder again to get the non-negative modulo.
  assign idle_src = ((q_cmd.op == OP_INSERT) ? q_cmd.key : q_cmd.look) ^ SIGN_BIT;
  assign pair_src = cmd.key ^ SIGN_BIT;
  assign hash_r = hash_u - hash_q * SLOTS_W;
  assign hash_rem = hash_r[CW-1:0];
  assign hash_home = (hash_rem >= HALF_REM) ? IW'(hash_rem - HALF_REM) :
                                              IW'(hash_rem + SLOTS_C - HALF_REM);

  assign q_ready = (state == S_IDLE) && !out_full;
  assign res_valid = out_full;

  logic match_key, slot_used;
  assign slot_used = (rd_stat == SLOT_USED);
  assign match_key = slot_used && (rd_key == cmd.look) &&
                     (cmd.op != OP_PAIR || rd_data != cmd.data);

  always_ff @(posedge clk) begin
    rd_stat <= stat_mem[addr];
    rd_key  <= key_mem[addr];
    rd_data <= data_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      out_full <= 1'b0;
      addr <= '0;
      cmd <= '0;
    end else begin
      if (res_valid && res_ready) out_full <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_valid && q_ready) begin
            cmd <= q_cmd;
            probes <= '0;
            hit_any <= 1'b0;
            insert_phase <= (q_cmd.op == OP_INSERT);
            hash_u <= idle_src;
            hash_q <= recip_quot(idle_src);
            res <= '0;
            if (q_cmd.op == OP_CLEAR) begin
              addr <= '0;
              state <= S_CLEAR;
            end else if (q_cmd.op == OP_INSERT || q_cmd.op == OP_SEARCH ||
                         q_cmd.op == OP_DELETE || q_cmd.op == OP_PAIR) begin
              state <= S_HASH;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_HASH: begin
          addr <= hash_home;
          state <= S_READ;
        end
        S_READ: state <= S_CHECK;
        S_CHECK: begin
          probes <= probes + CW'(1);
          state <= S_READ;
          addr <= next_slot(addr);
          if (insert_phase) begin
            if (rd_stat != SLOT_USED) begin
              stat_mem[addr] <= SLOT_USED;
              key_mem[addr] <= cmd.key;
              data_mem[addr] <= cmd.data;
              res.status <= (cmd.op == OP_PAIR) ? RES_MISS : RES_OK;
              state <= S_DONE;
            end else if (probes == CW'(TABLE_SLOTS - 1)) begin
              res.status <= RES_FULL;
              state <= S_DONE;
            end
          end else if (cmd.op == OP_DELETE) begin
            if (match_key) begin
              stat_mem[addr] <= SLOT_GONE;
            end
            if (rd_stat == SLOT_EMPTY || probes == CW'(TABLE_SLOTS - 1)) begin
              res.status <= (hit_any || match_key) ? RES_OK : RES_MISS;
              state <= S_DONE;
            end
            hit_any <= hit_any | match_key;
          end else begin
            if (match_key) begin
              res.found <= 1'b1;
              res.data <= rd_data;
              state <= S_DONE;
            end else if (rd_stat == SLOT_EMPTY || probes == CW'(TABLE_SLOTS - 1)) begin
              if (cmd.op == OP_PAIR) begin
                insert_phase <= 1'b1;
                probes <= '0;
                hash_u <= pair_src;
                hash_q <= recip_quot(pair_src);
                state <= S_HASH;
              end else begin
                res.status <= RES_MISS;
                state <= S_DONE;
              end
            end
          end
        end
        S_CLEAR: begin
          stat_mem[addr] <= SLOT_EMPTY;
          addr <= next_slot(addr);
          if (addr == LAST) state <= (cmd.op == OP_CLEAR) ? S_DONE : S_IDLE;
        end
        S_DONE: begin
          if (!out_full || (res_valid && res_ready)) begin
            out_full <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `LPHT_ASSERT(a_ready_idle, clk, rst, q_ready |-> (state == S_IDLE))
  `LPHT_ASSERT(a_probe_bound, clk, rst, (state == S_CHECK) |-> (probes < CW'(TABLE_SLOTS)))
  `LPHT_ASSERT(a_res_hold, clk, rst, (res_valid && !res_ready) |=> res_valid)
endmodule

FILE: hdl/linear_probe_hash_table.sv
// Linear-probing hash table, fed by a stream of command words.
// Slave channel s_axis_*: tdata = {data_in, key}, tuser = opcode
//   (0 insert, 1 search, 2 delete, 3 pair step, 4 clear). The user must write pair_target
//   by cfg_we/cfg_wdata only while the block is idle; the block does not enforce this.
// Master channel m_axis_*: tdata = {status, data_out, found}, one word per command.
// A two-entry queue decouples command intake from the probe engine, so
// commands are accepted while a result waits on m_axis_tready.
// Each probed slot takes a registered memory read (S_READ), then a check
// (S_CHECK); a command also passes S_HASH before its walk and S_DONE after it.
// Clear sweeps the slot status memory one slot at a time.
// A pair step that misses does a second walk to insert.
// Throughput: the engine takes the next command the cycle after a result leaves.
// Reset: clears pair_target and sweeps the slot status memory empty
// before the first command leaves the queue.
// A stalled receiver holds the result; the engine waits, the queue fills,
// then s_axis_tready falls.
module linear_probe_hash_table #(
  parameter int unsigned TABLE_SLOTS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,     // pair_target
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // [31:0] key, [63:32] data_in
  input  logic [2:0]  s_axis_tuser,  // [2:0] opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // [0] found, [32:1] data_out, [34:33] status
);
  import lpht_pkg::*;

  logic q_valid, q_ready;
  cmd_t q_cmd;
  res_t res;

  // Front: hold pair_target, compute partner key, queue commands.
  lpht_front u_front (
    .clk, .rst, .cfg_we, .cfg_wdata,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_op(s_axis_tuser), .in_key(s_axis_tdata[31:0]),
    .in_data(s_axis_tdata[63:32]),
    .q_valid, .q_ready, .q_cmd
  );

  // Back: walk the probe run one slot at a time.
  lpht_back #(.TABLE_SLOTS(TABLE_SLOTS)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_cmd,
    .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res
  );

  assign m_axis_tdata = {5'd0, res.status, res.data, res.found};
endmodule

FILE: dv/linear_probe_hash_table_checker.sv
module linear_probe_hash_table_checker #(
  parameter int unsigned TABLE_SLOTS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,
  input  logic [2:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,
  output int          fail_count,
  output int          pending_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import lpht_pkg::*;

  typedef struct packed {
    logic        found;
    logic [31:0] data;
    logic [1:0]  status;
  } answer_t;

  logic [31:0] target_q;
  logic [1:0]  slot_state [TABLE_SLOTS];
  logic [31:0] slot_key [TABLE_SLOTS];
  logic [31:0] slot_data [TABLE_SLOTS];
  answer_t     answer_q[$];

  function automatic int unsigned home_of(logic [31:0] k);
    int r;
    r = int'($signed(k)) % int'(TABLE_SLOTS);
    if (r < 0) r += TABLE_SLOTS;
    return r;
  endfunction

  // Walk the run; return the slot of the first live match or -1.
  function automatic int lookup(logic [31:0] k, bit skip, logic [31:0] avoid);
    int unsigned h, s;
    h = home_of(k);
    for (int unsigned i = 0; i < TABLE_SLOTS; i++) begin
      s = (h + i) % TABLE_SLOTS;
      if (slot_state[s] == SLOT_EMPTY) return -1;
      if (slot_state[s] == SLOT_USED && slot_key[s] == k &&
          (!skip || slot_data[s] != avoid)) return s;
    end
    return -1;
  endfunction

  function automatic bit store(logic [31:0] k, logic [31:0] d);
    int unsigned h, s;
    h = home_of(k);
    for (int unsigned i = 0; i < TABLE_SLOTS; i++) begin
      s = (h + i) % TABLE_SLOTS;
      if (slot_state[s] != SLOT_USED) begin
        slot_state[s] = SLOT_USED;
        slot_key[s] = k;
        slot_data[s] = d;
        return 1;
      end
    end
    return 0;
  endfunction

  function automatic bit remove(logic [31:0] k);
    int unsigned h, s;
    bit any;
    h = home_of(k);
    any = 0;
    for (int unsigned i = 0; i < TABLE_SLOTS; i++) begin
      s = (h + i) % TABLE_SLOTS;
      if (slot_state[s] == SLOT_EMPTY) break;
      if (slot_state[s] == SLOT_USED && slot_key[s] == k) begin
        slot_state[s] = SLOT_GONE;
        any = 1;
      end
    end
    return any;
  endfunction

  function automatic answer_t apply_command(logic [2:0] op, logic [31:0] k, logic [31:0] d);
    answer_t a;
    int s;
    a = '0;
    case (op)
      OP_INSERT: a.status = store(k, d) ? RES_OK : RES_FULL;
      OP_SEARCH: begin
        s = lookup(k, 0, '0);
        if (s >= 0) begin
          a.found = 1;
          a.data = slot_data[s];
        end else a.status = RES_MISS;
      end
      OP_DELETE: a.status = remove(k) ? RES_OK : RES_MISS;
      OP_PAIR: begin
        s = lookup(target_q - k, 1, d);
        if (s >= 0) begin
          a.found = 1;
          a.data = slot_data[s];
        end else a.status = store(k, d) ? RES_MISS : RES_FULL;
      end
      OP_CLEAR: for (int i = 0; i < TABLE_SLOTS; i++) slot_state[i] = SLOT_EMPTY;
      default: ;
    endcase
    return a;
  endfunction

  assign pending_count = answer_q.size();

  always @(posedge clk) begin
    answer_t got, want;
    if (rst) begin
      target_q <= '0;
      for (int i = 0; i < TABLE_SLOTS; i++) slot_state[i] = SLOT_EMPTY;
      answer_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) target_q <= cfg_wdata;
      if (s_axis_tvalid && s_axis_tready)
        answer_q.push_back(apply_command(s_axis_tuser, s_axis_tdata[31:0],
                                         s_axis_tdata[63:32]));
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[0], m_axis_tdata[32:1], m_axis_tdata[34:33]};
        if (answer_q.size() == 0) begin
          $display("%0t: unexpected word %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = answer_q.pop_front();
          if (got.found !== want.found || got.data !== want.data ||
              got.status !== want.status) begin
            $display("%0t: mismatch expected found=%0d data=%h status=%0d, got found=%0d data=%h status=%0d",
                     $time, want.found, want.data, want.status, got.found, got.data, got.status);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

FILE: dv/linear_probe_hash_table_tb.sv
module linear_probe_hash_table_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lpht_pkg::*;

  localparam int unsigned SLOTS = 256;
  localparam int WATCHDOG = 20000;  // > clear sweep plus a full-table walk pair

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic [31:0] cfg_wdata = '0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;  // [31:0] key, [63:32] data_in
  logic [2:0]  s_axis_tuser = '0;  // [2:0] opcode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [39:0] m_axis_tdata;       // [0] found, [32:1] data_out, [34:33] status
  int          fail_count, pending_count;
  int          send_idle = 0, recv_stall = 0;  // percent
  int          quiet = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  linear_probe_hash_table #(.TABLE_SLOTS(SLOTS)) u_top (.*);

  linear_probe_hash_table_checker #(.TABLE_SLOTS(SLOTS)) u_check (.*);

  // Randomly stall the result side.
  always @(posedge clk)
    m_axis_tready <= !rst && ($urandom_range(99) >= recv_stall);

  // Watchdog: count cycles in which no word moves on either side.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > WATCHDOG) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Send one command word; hold valid until accepted. Valid stays high after
  // acceptance so the next word can follow; idle cycles and drain() drop it.
  task automatic send_word(logic [2:0] op, logic [31:0] k, logic [31:0] d);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser <= op;
    s_axis_tdata <= {d, k};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Wait for all answers, then let the engine finish any clear sweep.
  task automatic drain();
    s_axis_tvalid <= 0;
    while (pending_count != 0) @(posedge clk);
    repeat (SLOTS + 20) @(posedge clk);
  endtask

  task automatic write_target(logic [31:0] v);
    drain();
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  // Keys mostly from a narrow pool so collisions, hits and clusters happen.
  function automatic logic [31:0] pick_key();
    case ($urandom_range(9))
      0: return $urandom;
      1: return 32'h8000_0000 + $urandom_range(600);
      2: return 32'h7FFF_FFFF - $urandom_range(600);
      default: return $signed($urandom_range(1200)) - 600;
    endcase
  endfunction

  function automatic logic [31:0] pick_data();
    return ($urandom_range(3) == 0) ? $urandom : $urandom_range(15);
  endfunction

  task automatic random_burst(int n, int pair_bias);
    logic [2:0] op;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 1) op = OP_CLEAR;
      else if (r < 2) op = 3'($urandom_range(5, 7));
      else if (r < 2 + pair_bias) op = OP_PAIR;
      else if (r < 50) op = OP_INSERT;
      else if (r < 75) op = OP_SEARCH;
      else op = OP_DELETE;
      send_word(op, pick_key(), pick_data());
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: extremes, every opcode, tombstones, wrap, two-sum cases.
    write_target(32'sd10);
    send_word(OP_SEARCH, 32'h0, 32'h0);           // miss on empty table
    send_word(OP_INSERT, 32'h8000_0000, 32'hFFFF_FFFF);
    send_word(OP_INSERT, 32'h7FFF_FFFF, 32'h0);
    send_word(OP_INSERT, 32'hFFFF_FFFF, 32'h1);   // -1 homes to last slot
    send_word(OP_INSERT, 32'd255, 32'h2);         // collides, wraps to slot 2
    send_word(OP_INSERT, 32'hFFFF_FFFF, 32'h3);   // duplicate key
    send_word(OP_SEARCH, 32'hFFFF_FFFF, 32'h0);
    send_word(OP_DELETE, 32'hFFFF_FFFF, 32'h0);   // both duplicates go
    send_word(OP_SEARCH, 32'd255, 32'h0);         // walks over tombstone
    send_word(OP_DELETE, 32'hFFFF_FFFF, 32'h0);   // nothing left
    send_word(OP_INSERT, 32'd511, 32'h4);         // reuses tombstone
    send_word(OP_PAIR, 32'd4, 32'd0);             // miss, stored
    send_word(OP_PAIR, 32'd6, 32'd1);             // partner at index 0
    send_word(OP_PAIR, 32'd5, 32'd2);             // miss
    send_word(OP_PAIR, 32'd5, 32'd2);             // same index: skipped
    send_word(OP_PAIR, 32'd5, 32'd3);             // hit index 2
    send_word(3'd5, 32'h1234, 32'h5678);
    send_word(3'd7, '1, '1);
    send_word(OP_CLEAR, 32'h0, 32'h0);
    send_word(OP_SEARCH, 32'd511, 32'h0);
    // Fill the table, then overflow on insert and on pair step.
    write_target(32'h8000_0000);
    for (int i = 0; i < SLOTS; i++) send_word(OP_INSERT, i * 7, $urandom);
    send_word(OP_INSERT, 32'h7FFF_FFFF, 32'h9);
    send_word(OP_PAIR, 32'h1, 32'h9);
    send_word(OP_SEARCH, 32'h7FFF_FFFF, 32'h0);   // full walk, no empty
    send_word(OP_CLEAR, 32'h0, 32'h0);

    // Random phases: no idling, sender idle, receiver stall, both.
    write_target(32'h7FFF_FFFF);
    random_burst(170, 15);
    send_idle = 85;
    write_target($urandom);
    random_burst(150, 15);
    send_idle = 0;
    recv_stall = 85;
    write_target(32'sd0);
    random_burst(200, 30);
    send_idle = 26;
    recv_stall = 26;
    write_target($signed($urandom_range(200)) - 100);
    random_burst(200, 30);
    send_idle = 0;
    recv_stall = 0;
    drain();  // sender pauses until every answer is back
    random_burst(50, 20);

    drain();
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
